// ----- rtl/pid_feedforward_velocity_controller_core_defines.svh -----
// Assertion macros for the velocity controller core.
`ifndef PID_FEEDFORWARD_VELOCITY_CONTROLLER_CORE_DEFINES_SVH
`define PID_FEEDFORWARD_VELOCITY_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define PFVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define PFVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pfvc_pkg.sv -----
// Types, register indexes and fixed-point helpers of the velocity controller.
`default_nettype none
package pfvc_pkg;

  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_STATIC_GAIN   = 3'd3,
    REG_VELOCITY_GAIN = 3'd4,
    REG_OUTPUT_MIN    = 3'd5,
    REG_OUTPUT_MAX    = 3'd6,
    REG_TICK_PERIOD   = 3'd7
  } reg_idx_t;

  typedef enum logic {
    KIND_TARGET = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FF_MUL,
    ST_FF_SUM,
    ST_DIFF,
    ST_MAG,
    ST_DT_MUL,
    ST_DT,
    ST_P,
    ST_INT,
    ST_I_MUL,
    ST_I,
    ST_D,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic signed [31:0] deriv_gain;
    logic signed [31:0] static_gain;
    logic signed [31:0] velocity_gain;
    logic signed [31:0] output_min;
    logic signed [31:0] output_max;
    logic        [31:0] tick_period;
  } cfg_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Sign-extend a Q16.16 value to a multiplier operand.
  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    sx33 = 33'(v);
  endfunction

  // Drop 16 fraction bits (floor) from a product and saturate to 32 bits.
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    logic signed [65:0] sh;
    sh = p >>> 16;
    if ((&sh[65:31]) || !(|sh[65:31])) begin
      qsat = sh[31:0];
    end else begin
      qsat = sh[65] ? S32_MIN : S32_MAX;
    end
  endfunction

  // Saturate an exact 33-bit difference to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
    if (d[32] == d[31]) begin
      sat33 = d[31:0];
    end else begin
      sat33 = d[32] ? S32_MIN : S32_MAX;
    end
  endfunction

  // Limit to hi first, then to lo.
  function automatic logic signed [31:0] clamp34(input logic signed [33:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [33:0] t;
    t = v;
    if (t > 34'(hi)) begin
      t = 34'(hi);
    end
    if (t < 34'(lo)) begin
      t = 34'(lo);
    end
    clamp34 = t[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfvc_regs.sv -----
// APB-style configuration register file of the velocity controller.
`default_nettype none
module pfvc_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [pfvc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready,
  output pfvc_pkg::cfg_t                   cfg
);
  import pfvc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.static_gain   <= '0;
      cfg_r.velocity_gain <= '0;
      cfg_r.output_min    <= S32_MIN;
      cfg_r.output_max    <= S32_MAX;
      cfg_r.tick_period   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_pwdata;
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= cfg_pwdata;
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= cfg_pwdata;
        REG_STATIC_GAIN:   cfg_r.static_gain   <= cfg_pwdata;
        REG_VELOCITY_GAIN: cfg_r.velocity_gain <= cfg_pwdata;
        REG_OUTPUT_MIN:    cfg_r.output_min    <= cfg_pwdata;
        REG_OUTPUT_MAX:    cfg_r.output_max    <= cfg_pwdata;
        REG_TICK_PERIOD:   cfg_r.tick_period   <= cfg_pwdata;
        default:           cfg_r.tick_period   <= cfg_r.tick_period;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:     cfg_prdata = cfg_r.prop_gain;
      REG_INTEG_GAIN:    cfg_prdata = cfg_r.integ_gain;
      REG_DERIV_GAIN:    cfg_prdata = cfg_r.deriv_gain;
      REG_STATIC_GAIN:   cfg_prdata = cfg_r.static_gain;
      REG_VELOCITY_GAIN: cfg_prdata = cfg_r.velocity_gain;
      REG_OUTPUT_MIN:    cfg_prdata = cfg_r.output_min;
      REG_OUTPUT_MAX:    cfg_prdata = cfg_r.output_max;
      REG_TICK_PERIOD:   cfg_prdata = cfg_r.tick_period;
      default:           cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pfvc_mul.sv -----
// Shared 33x33 signed multiplier with registered product.
`default_nettype none
module pfvc_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed      [65:0] prod
);
  logic signed [65:0] prod_r;

  // Register every product; the sequencer reads it in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= 66'(op_a) * 66'(op_b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ----- rtl/pid_feedforward_velocity_controller_core.sv -----
// Top level of the PID velocity controller with static and velocity feedforward.
`default_nettype none
`include "pid_feedforward_velocity_controller_core_defines.svh"
// Velocity regulator in signed Q16.16. An item with kind 0 stores a new target,
// clears the integral and loads the control value with the clamped feedforward
// term (zero for a zero target); an item with kind 1 carries a reading and a
// tick timestamp and runs one PID update on the running control value. Each
// item gives one result: the new control value and the stored target. All
// products go through one shared 33x33 multiplier with a registered output,
// stepped by a small sequencer, and the block takes one item at a time: an
// update item makes five passes through the multiplier plus difference, sum
// and clamp steps, and the next item is taken only once the result has been
// accepted on out_ready.
// Configuration registers sit at byte addresses 4*i and may only be written
// while the block is idle.
module pid_feedforward_velocity_controller_core #(
  parameter logic signed [31:0] INTEGRAL_MAX = 32'sh7FFF_FFFF,
  parameter logic signed [31:0] INTEGRAL_MIN = 32'sh8000_0000
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic signed [31:0]          in_target_velocity,
  input  wire logic signed [31:0]          in_measured_velocity,
  input  wire logic        [63:0]          in_timestamp,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed      [31:0]          out_control_output,
  output logic signed      [31:0]          out_current_target,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [pfvc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);
  import pfvc_pkg::*;

  cfg_t cfg;

  st_t  state_r, state_nxt;
  kind_t kind_r;

  // Architectural state
  logic signed [31:0] target_r, integ_r, prev_rd_r, ctrl_r;
  logic        [63:0] prev_tick_r;

  // Per-item working registers
  logic signed [31:0] rd_r, err_r, dif_r, dt_r, p_r, i_r;
  logic        [63:0] ts_r, diff_r;
  logic        [31:0] mag_r;
  logic               neg_r, big_r;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic signed [31:0] qprod;
  logic        [63:0] mag64;
  logic        [49:0] dt_q;
  logic signed [31:0] dt_val;
  logic signed [33:0] ff_sum, int_sum, ctrl_sum;
  logic               in_acc;

  pfvc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pfvc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = (state_r == ST_OUT);
  assign in_acc             = in_valid && in_ready;
  assign out_control_output = ctrl_r;
  assign out_current_target = target_r;

  // Product of the previous cycle, Q16.16 and saturated
  assign qprod = qsat(prod);

  // Tick difference magnitude
  assign mag64 = diff_r[63] ? (64'd0 - diff_r) : diff_r;

  // dt from the registered magnitude times tick period
  assign dt_q = prod[65:16];
  always_comb begin
    if (cfg.tick_period == '0) begin
      dt_val = '0;
    end else if (big_r) begin
      dt_val = neg_r ? S32_MIN : S32_MAX;
    end else if (neg_r) begin
      if ((|dt_q[49:32]) || (dt_q[31] && (|dt_q[30:0]))) begin
        dt_val = S32_MIN;
      end else begin
        dt_val = 32'd0 - dt_q[31:0];
      end
    end else begin
      dt_val = (|dt_q[49:31]) ? S32_MAX : dt_q[31:0];
    end
  end

  // Sums ahead of the clamps
  assign ff_sum   = (target_r[31] ? (34'sd0 - 34'(cfg.static_gain)) : 34'(cfg.static_gain))
                  + 34'(qprod);
  assign int_sum  = 34'(integ_r) + 34'(qprod);
  assign ctrl_sum = 34'(ctrl_r) + 34'(p_r) + 34'(i_r) + 34'(qprod);

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the item and steer the multiplier
  always_comb begin
    state_nxt = state_r;
    op_a      = '0;
    op_b      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (kind_t'(in_kind) == KIND_TARGET) ? ST_FF_MUL : ST_DIFF;
        end
      end
      ST_FF_MUL: begin
        op_a      = sx33(cfg.velocity_gain);
        op_b      = sx33(target_r);
        state_nxt = ST_FF_SUM;
      end
      ST_FF_SUM: state_nxt = ST_OUT;
      ST_DIFF:   state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_DT_MUL;
      ST_DT_MUL: begin
        op_a      = {1'b0, mag_r};
        op_b      = {1'b0, cfg.tick_period};
        state_nxt = ST_DT;
      end
      ST_DT: begin
        op_a      = sx33(cfg.prop_gain);
        op_b      = sx33(err_r);
        state_nxt = ST_P;
      end
      ST_P: begin
        op_a      = sx33(dt_r);
        op_b      = sx33(err_r);
        state_nxt = ST_INT;
      end
      ST_INT:    state_nxt = ST_I_MUL;
      ST_I_MUL: begin
        op_a      = sx33(cfg.integ_gain);
        op_b      = sx33(integ_r);
        state_nxt = ST_I;
      end
      ST_I: begin
        op_a      = sx33(cfg.deriv_gain);
        op_b      = sx33(dif_r);
        state_nxt = ST_D;
      end
      ST_D:      state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Update the controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      integ_r     <= '0;
      prev_rd_r   <= '0;
      prev_tick_r <= '0;
      ctrl_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (kind_t'(in_kind) == KIND_TARGET)) begin
            target_r <= in_target_velocity;
            integ_r  <= '0;
          end
        end
        ST_FF_SUM: begin
          ctrl_r <= (target_r == '0) ? 32'sd0
                                     : clamp34(ff_sum, cfg.output_min, cfg.output_max);
        end
        ST_DIFF: begin
          prev_tick_r <= ts_r;
          prev_rd_r   <= rd_r;
        end
        ST_INT: integ_r <= clamp34(int_sum, INTEGRAL_MIN, INTEGRAL_MAX);
        ST_D:   ctrl_r  <= clamp34(ctrl_sum, cfg.output_min, cfg.output_max);
        default: begin
          ctrl_r <= ctrl_r;
        end
      endcase
    end
  end

  // Capture the item and the intermediate terms
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_r <= kind_t'(in_kind);
          rd_r   <= in_measured_velocity;
          ts_r   <= in_timestamp;
        end
      end
      ST_DIFF: begin
        diff_r <= ts_r - prev_tick_r;
        err_r  <= sat33(33'(target_r) - 33'(rd_r));
        dif_r  <= sat33(33'(prev_rd_r) - 33'(rd_r));
      end
      ST_MAG: begin
        neg_r <= diff_r[63];
        big_r <= |mag64[63:32];
        mag_r <= mag64[31:0];
      end
      ST_DT:  dt_r <= dt_val;
      ST_P:   p_r  <= qprod;
      ST_I:   i_r  <= qprod;
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  // Checks on the sequencer and the integrator
  `PFVC_ASSERT_NOW(a_no_accept_while_result, out_valid, !in_ready, "input taken with result pending")
  `PFVC_ASSERT_NEXT(a_idle_after_result, out_valid && out_ready, in_ready, "not idle after result")
  `PFVC_ASSERT_NOW(a_integ_range, 1'b1, (integ_r >= INTEGRAL_MIN) && (integ_r <= INTEGRAL_MAX), "integral out of range")
  `PFVC_ASSERT_NOW(a_target_clears_integ, out_valid && (kind_r == KIND_TARGET), integ_r == '0, "integral not cleared by target")

endmodule
`default_nettype wire
